/* rtl/bate_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bate_pkg
// Shared types and constants for the bounded array table engine.
// ----------------------------------------------------------------------------
package bate_pkg;

  localparam int unsigned DepthDefault = 64;
  localparam int unsigned MaxResults   = 64;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_SORT   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADIDX  = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RD_INDEX   = 3'd0,
    RD_PTR     = 3'd1,
    RD_PTR_INC = 3'd2,
    RD_PTR_DEC = 3'd3,
    RD_OUTER   = 3'd4
  } rd_src_t;

  typedef enum logic [1:0] {
    WR_VALUE = 2'd0,
    WR_RDATA = 2'd1,
    WR_KEY   = 2'd2
  } wr_src_t;

  typedef enum logic [2:0] {
    PTR_HOLD  = 3'd0,
    PTR_INDEX = 3'd1,
    PTR_ZERO  = 3'd2,
    PTR_OUTER = 3'd3,
    PTR_INC   = 3'd4,
    PTR_DEC   = 3'd5
  } ptr_op_t;

  typedef enum logic [1:0] {
    EMIT_ZERO  = 2'd0,
    EMIT_RDATA = 2'd1,
    EMIT_HELD  = 2'd2
  } emit_src_t;

  // controller -> datapath
  typedef struct packed {
    logic      capture;
    logic      rd_en;
    rd_src_t   rd_src;
    logic      wr_en;
    wr_src_t   wr_src;
    ptr_op_t   ptr_op;
    logic      outer_init;
    logic      outer_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      key_load;
    logic      find_clear;
    logic      find_hit;
    logic      emit;
    status_t   emit_status;
    logic      emit_last;
    emit_src_t emit_src;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op_kind;
    logic       full;
    logic       idx_ok;
    logic       del_more;
    logic       find_more;
    logic       hit;
    logic       hold_vld;
    logic       sort_more;
    logic       ptr_nz;
    logic       gt;
  } flags_t;

endpackage

/* rtl/bounded_array_table_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_table_engine_unit
// Bounded table of signed words: append, delete, read, find and sort.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive kind/index/value with start; a transaction is
//   taken at a rising edge with start high and busy low. busy stays high
//   until the final result of that transaction has been registered.
//   Result channel: each result sits on status/data/match_index/
//   entries_used/last for one cycle with strobe high. The receiver cannot
//   stall; it must take every strobed result. last marks the final result.
//   The table read is registered. bad index, full and unused kinds are
//   answered at decode; append and read take one table access; delete
//   walks the entries past index; find walks the filled entries and stops
//   once 64 hits are taken; sort visits every entry past the first and
//   moves each shifted entry.
//   One transaction is in flight at a time; the next may be taken in the
//   cycle its predecessor's last result is shown.
//   Reset (rst, synchronous) empties the table (fill count zero), drops any
//   transaction in flight and clears strobe. Table contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_array_table_engine_unit #(
  parameter int unsigned DEPTH = bate_pkg::DepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic [5:0]         index,
  input  logic signed [31:0] value,
  output logic               strobe,
  output logic [1:0]         status,
  output logic signed [31:0] data,
  output logic [5:0]         match_index,
  output logic [6:0]         entries_used,
  output logic               last
);

  // command/status bundles between sequencer and datapath
  bate_pkg::cmd_t   cmd;
  bate_pkg::flags_t flags;

  bate_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  bate_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .kind         (kind),
    .index        (index),
    .value        (value),
    .cmd          (cmd),
    .flags        (flags),
    .strobe       (strobe),
    .status       (status),
    .data         (data),
    .match_index  (match_index),
    .entries_used (entries_used),
    .last         (last)
  );

endmodule

/* rtl/bate_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bate_ctrl
// Sequencer for the table operations; drives datapath commands.
// ----------------------------------------------------------------------------
module bate_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  bate_pkg::flags_t flags,
  output bate_pkg::cmd_t   cmd
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_DECODE    = 13'b0000000000010,
    S_DONE      = 13'b0000000000100,
    S_READ_WAIT = 13'b0000000001000,
    S_DEL_CHK   = 13'b0000000010000,
    S_DEL_WR    = 13'b0000000100000,
    S_FIND_CHK  = 13'b0000001000000,
    S_FIND_CMP  = 13'b0000010000000,
    S_FIND_END  = 13'b0000100000000,
    S_SORT_CHK  = 13'b0001000000000,
    S_SORT_KEY  = 13'b0010000000000,
    S_SORT_J    = 13'b0100000000000,
    S_SORT_CMP  = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (flags.op_kind)
          bate_pkg::KIND_APPEND: begin
            if (flags.full) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bate_pkg::ST_FULL;
              cmd.emit_last   = 1'b1;
              state_next      = S_IDLE;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wr_src  = bate_pkg::WR_VALUE;
              cmd.cnt_inc = 1'b1;
              state_next  = S_DONE;
            end
          end
          bate_pkg::KIND_DELETE: begin
            if (!flags.idx_ok) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bate_pkg::ST_BADIDX;
              cmd.emit_last   = 1'b1;
              state_next      = S_IDLE;
            end else begin
              cmd.ptr_op = bate_pkg::PTR_INDEX;
              state_next = S_DEL_CHK;
            end
          end
          bate_pkg::KIND_READ: begin
            if (!flags.idx_ok) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = bate_pkg::ST_BADIDX;
              cmd.emit_last   = 1'b1;
              state_next      = S_IDLE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = bate_pkg::RD_INDEX;
              state_next = S_READ_WAIT;
            end
          end
          bate_pkg::KIND_FIND: begin
            cmd.ptr_op     = bate_pkg::PTR_ZERO;
            cmd.find_clear = 1'b1;
            state_next     = S_FIND_CHK;
          end
          bate_pkg::KIND_SORT: begin
            cmd.outer_init = 1'b1;
            state_next     = S_SORT_CHK;
          end
          default: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = bate_pkg::ST_OK;
            cmd.emit_last   = 1'b1;
            state_next      = S_IDLE;
          end
        endcase
      end
      S_DONE: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = bate_pkg::ST_OK;
        cmd.emit_last   = 1'b1;
        state_next      = S_IDLE;
      end
      S_READ_WAIT: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = bate_pkg::ST_OK;
        cmd.emit_last   = 1'b1;
        cmd.emit_src    = bate_pkg::EMIT_RDATA;
        state_next      = S_IDLE;
      end
      S_DEL_CHK: begin
        if (flags.del_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = bate_pkg::RD_PTR_INC;
          state_next = S_DEL_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = bate_pkg::WR_RDATA;
        cmd.ptr_op = bate_pkg::PTR_INC;
        state_next = S_DEL_CHK;
      end
      S_FIND_CHK: begin
        if (flags.find_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = bate_pkg::RD_PTR;
          state_next = S_FIND_CMP;
        end else begin
          state_next = S_FIND_END;
        end
      end
      S_FIND_CMP: begin
        // a new hit releases the previously held one, which is not the last
        if (flags.hit) begin
          cmd.find_hit = 1'b1;
          if (flags.hold_vld) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = bate_pkg::ST_OK;
            cmd.emit_src    = bate_pkg::EMIT_HELD;
          end
        end
        cmd.ptr_op = bate_pkg::PTR_INC;
        state_next = S_FIND_CHK;
      end
      S_FIND_END: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = 1'b1;
        if (flags.hold_vld) begin
          cmd.emit_status = bate_pkg::ST_OK;
          cmd.emit_src    = bate_pkg::EMIT_HELD;
        end else begin
          cmd.emit_status = bate_pkg::ST_NOMATCH;
        end
        state_next = S_IDLE;
      end
      S_SORT_CHK: begin
        if (flags.sort_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = bate_pkg::RD_OUTER;
          cmd.ptr_op = bate_pkg::PTR_OUTER;
          state_next = S_SORT_KEY;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SORT_KEY: begin
        cmd.key_load = 1'b1;
        state_next   = S_SORT_J;
      end
      S_SORT_J: begin
        if (flags.ptr_nz) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = bate_pkg::RD_PTR_DEC;
          state_next = S_SORT_CMP;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_src    = bate_pkg::WR_KEY;
          cmd.outer_inc = 1'b1;
          state_next    = S_SORT_CHK;
        end
      end
      S_SORT_CMP: begin
        if (flags.gt) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = bate_pkg::WR_RDATA;
          cmd.ptr_op = bate_pkg::PTR_DEC;
          state_next = S_SORT_J;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_src    = bate_pkg::WR_KEY;
          cmd.outer_inc = 1'b1;
          state_next    = S_SORT_CHK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bate_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bate_dpath
// Entry memory, fill count, walk pointers, sort key and result registers.
// ----------------------------------------------------------------------------
module bate_dpath #(
  parameter int unsigned DEPTH = bate_pkg::DepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          kind,
  input  logic [5:0]          index,
  input  logic signed [31:0]  value,
  input  bate_pkg::cmd_t      cmd,
  output bate_pkg::flags_t    flags,
  output logic                strobe,
  output logic [1:0]          status,
  output logic signed [31:0]  data,
  output logic [5:0]          match_index,
  output logic [6:0]          entries_used,
  output logic                last
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  logic [2:0]         op_kind;
  logic [5:0]         op_index;
  logic signed [31:0] op_value;
  logic [CW-1:0]      count;
  logic [CW-1:0]      ptr;
  logic [CW-1:0]      outer;
  logic signed [31:0] key;
  logic [AW-1:0]      hold_idx;
  logic               hold_vld;
  logic [6:0]         nmatch;

  logic [CW-1:0]      ptr_inc;
  logic [CW-1:0]      ptr_dec;
  logic [CW-1:0]      ptr_next;
  logic [AW+5:0]      idx_ext;
  logic [AW+5:0]      hold_ext;
  logic [CW+6:0]      count_ext;

  assign ptr_inc   = ptr + CW'(1);
  assign ptr_dec   = ptr - CW'(1);
  assign idx_ext   = (AW + 6)'(op_index);
  assign hold_ext  = (AW + 6)'(hold_idx);
  assign count_ext = (CW + 7)'(count);

  // status back to the sequencer
  always_comb begin
    flags.op_kind   = op_kind;
    flags.full      = (count == CW'(DEPTH));
    flags.idx_ok    = ((CW + 6)'(op_index) < (CW + 6)'(count));
    flags.del_more  = ((CW + 1)'(ptr) + (CW + 1)'(1) < (CW + 1)'(count));
    flags.find_more = (ptr < count) && (nmatch < 7'(bate_pkg::MaxResults));
    flags.hit       = (rdata == op_value);
    flags.hold_vld  = hold_vld;
    flags.sort_more = (outer < count);
    flags.ptr_nz    = (ptr != '0);
    flags.gt        = (rdata > key);
  end

  always_comb begin
    case (cmd.rd_src)
      bate_pkg::RD_INDEX:   raddr = idx_ext[AW-1:0];
      bate_pkg::RD_PTR:     raddr = ptr[AW-1:0];
      bate_pkg::RD_PTR_INC: raddr = ptr_inc[AW-1:0];
      bate_pkg::RD_PTR_DEC: raddr = ptr_dec[AW-1:0];
      bate_pkg::RD_OUTER:   raddr = outer[AW-1:0];
      default:              raddr = ptr[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd.wr_src)
      bate_pkg::WR_VALUE: begin
        waddr = count[AW-1:0];
        wdata = op_value;
      end
      bate_pkg::WR_RDATA: begin
        waddr = ptr[AW-1:0];
        wdata = rdata;
      end
      bate_pkg::WR_KEY: begin
        waddr = ptr[AW-1:0];
        wdata = key;
      end
      default: begin
        waddr = ptr[AW-1:0];
        wdata = key;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    case (cmd.ptr_op)
      bate_pkg::PTR_HOLD:  ptr_next = ptr;
      bate_pkg::PTR_INDEX: ptr_next = CW'(idx_ext[AW-1:0]);
      bate_pkg::PTR_ZERO:  ptr_next = '0;
      bate_pkg::PTR_OUTER: ptr_next = outer;
      bate_pkg::PTR_INC:   ptr_next = ptr_inc;
      bate_pkg::PTR_DEC:   ptr_next = ptr_dec;
      default:             ptr_next = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.capture) begin
      op_kind  <= kind;
      op_index <= index;
      op_value <= value;
    end
    if (cmd.outer_init) begin
      outer <= CW'(1);
    end else if (cmd.outer_inc) begin
      outer <= outer + CW'(1);
    end
    if (cmd.key_load) begin
      key <= rdata;
    end
    if (cmd.find_hit) begin
      hold_idx <= ptr[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      hold_vld <= 1'b0;
      nmatch   <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.find_clear) begin
        hold_vld <= 1'b0;
        nmatch   <= '0;
      end else if (cmd.find_hit) begin
        hold_vld <= 1'b1;
        nmatch   <= nmatch + 7'd1;
      end
    end
  end

  // result register; entries_used is taken from the settled count
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
    if (cmd.emit) begin
      status       <= cmd.emit_status;
      last         <= cmd.emit_last;
      entries_used <= count_ext[6:0];
      data         <= (cmd.emit_src == bate_pkg::EMIT_RDATA) ? rdata : '0;
      match_index  <= (cmd.emit_src == bate_pkg::EMIT_HELD) ? hold_ext[5:0] : 6'd0;
    end
  end

endmodule

/* rtl/bate_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bate_chk
// Port-level checks for the table engine, bound to the top level.
// ----------------------------------------------------------------------------
module bate_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               strobe,
  input logic [1:0]         status,
  input logic signed [31:0] data,
  input logic [5:0]         match_index,
  input logic [6:0]         entries_used,
  input logic               last
);

  // reset leaves the block idle and quiet
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!busy && !strobe))
    else $error("busy or strobe after reset");

  // a taken transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // more results pending means still busy
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("intermediate result while idle");

  // a result is fully known and never followed by another at once
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (!$isunknown({status, data, match_index, entries_used, last}) ##1 !strobe))
    else $error("unknown result or strobes in consecutive cycles");

  // no-match is a single, final result with zero payload
  a_nomatch_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == bate_pkg::ST_NOMATCH)) |->
      (last && (data == '0) && (match_index == '0)))
    else $error("no-match result not final or not zero");

endmodule

bind bounded_array_table_engine_unit bate_chk u_bate_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .strobe       (strobe),
  .status       (status),
  .data         (data),
  .match_index  (match_index),
  .entries_used (entries_used),
  .last         (last)
);

/* bench/bounded_array_table_engine_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_table_engine_unit_test
// Self-checking bench for the bounded table engine. A scoreboard keeps its
// own copy of the table and fill count and predicts every report of each
// accepted transaction: append, delete, read, find (one report per hit) and
// insertion sort. Directed corner cases come first, then a fill-to-full
// burst, then weighted random traffic under several sender idle patterns.
// ----------------------------------------------------------------------------
module bounded_array_table_engine_unit_test;

  localparam int unsigned Depth       = bate_pkg::DepthDefault;
  // Bound for the slowest plausible run: ~230 transactions, each at worst a
  // full-table sort plus the longest sender gap, with a 4x margin.
  localparam int unsigned CycleLimit  = 4_000_000;
  // Every transaction ends in a strobed report, so a short tail suffices.
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned PhaseItems  = 35;
  localparam int unsigned MaxShown    = 10;

  // One expected report of the result channel.
  typedef struct packed {
    bate_pkg::status_t  status;
    logic signed [31:0] data;
    logic [5:0]         match_index;
    logic [6:0]         used;
    logic               last;
  } table_report_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the table, predicts reports at accept time, and
  // checks strobed reports in order.
  // --------------------------------------------------------------------------
  class table_ledger;
    logic signed [31:0] words [Depth];
    int unsigned        fill;
    table_report_t      pending [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        longest_find;
    int unsigned        full_refusals;
    int unsigned        kind_seen [8];

    function new();
      fill          = 0;
      mismatches    = 0;
      checked       = 0;
      longest_find  = 0;
      full_refusals = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    // queue one report; fill count is taken after the operation
    function void queue_report(bate_pkg::status_t st, logic signed [31:0] d,
                               logic [5:0] mi, logic lst);
      table_report_t r;
      r.status      = st;
      r.data        = d;
      r.match_index = mi;
      r.used        = 7'(fill);
      r.last        = lst;
      pending.push_back(r);
    endfunction

    // an accepted transaction: update the mirror and queue its reports
    function void take_command(logic [2:0] kind, logic [5:0] idx,
                               logic signed [31:0] val);
      int unsigned        hits;
      int                 j;
      logic signed [31:0] key;
      table_report_t      tail;
      hits = 0;
      kind_seen[kind]++;
      case (kind)
        bate_pkg::KIND_APPEND: begin
          if (fill < Depth) begin
            words[fill] = val;
            fill++;
            queue_report(bate_pkg::ST_OK, '0, '0, 1'b1);
          end else begin
            full_refusals++;
            queue_report(bate_pkg::ST_FULL, '0, '0, 1'b1);
          end
        end
        bate_pkg::KIND_DELETE: begin
          if (idx < fill) begin
            for (int i = idx; i + 1 < fill; i++) words[i] = words[i + 1];
            fill--;
            queue_report(bate_pkg::ST_OK, '0, '0, 1'b1);
          end else begin
            queue_report(bate_pkg::ST_BADIDX, '0, '0, 1'b1);
          end
        end
        bate_pkg::KIND_READ: begin
          if (idx < fill) queue_report(bate_pkg::ST_OK, words[idx], '0, 1'b1);
          else            queue_report(bate_pkg::ST_BADIDX, '0, '0, 1'b1);
        end
        bate_pkg::KIND_FIND: begin
          for (int i = 0; i < fill && hits < bate_pkg::MaxResults; i++) begin
            if (words[i] == val) begin
              queue_report(bate_pkg::ST_OK, '0, 6'(i), 1'b0);
              hits++;
            end
          end
          if (hits == 0) begin
            queue_report(bate_pkg::ST_NOMATCH, '0, '0, 1'b1);
          end else begin
            // flag the final hit
            tail      = pending.pop_back();
            tail.last = 1'b1;
            pending.push_back(tail);
          end
          if (hits > longest_find) longest_find = hits;
        end
        bate_pkg::KIND_SORT: begin
          // stable ascending insertion sort, signed compare
          for (int i = 1; i < fill; i++) begin
            key = words[i];
            j   = i;
            while (j > 0 && words[j - 1] > key) begin
              words[j] = words[j - 1];
              j--;
            end
            words[j] = key;
          end
          queue_report(bate_pkg::ST_OK, '0, '0, 1'b1);
        end
        default: queue_report(bate_pkg::ST_OK, '0, '0, 1'b1);
      endcase
    endfunction

    // a strobed report from the block
    function void check_report(logic [1:0] st, logic signed [31:0] d,
                               logic [5:0] mi, logic [6:0] used, logic lst);
      table_report_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown)
          $display("ERROR %0t: unexpected report status=%0d data=%0d match=%0d used=%0d last=%0b",
                   $time, st, d, mi, used, lst);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (st !== want.status || d !== want.data || mi !== want.match_index ||
          used !== want.used || lst !== want.last) begin
        mismatches++;
        if (mismatches <= MaxShown) begin
          $display("ERROR %0t: report mismatch", $time);
          $display("  expected status=%0d data=%0d match=%0d used=%0d last=%0b",
                   want.status, want.data, want.match_index, want.used, want.last);
          $display("  actual   status=%0d data=%0d match=%0d used=%0d last=%0b",
                   st, d, mi, used, lst);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         kind;
  logic [5:0]         index;
  logic signed [31:0] value;
  logic               strobe;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [5:0]         match_index;
  logic [6:0]         entries_used;
  logic               last;

  bounded_array_table_engine_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .index        (index),
    .value        (value),
    .strobe       (strobe),
    .status       (status),
    .data         (data),
    .match_index  (match_index),
    .entries_used (entries_used),
    .last         (last)
  );

  table_ledger        ledger;
  int unsigned        idle_pct;   // chance in 100 of a sender gap
  int unsigned        cycles;
  int unsigned        phase_idle [4] = '{0, 65, 0, 16};
  // small pool so finds hit and sorts see duplicates and sign extremes
  logic signed [31:0] value_pool [8] = '{32'sd0, -32'sd1, 32'sd1, 32'sd7,
                                         32'sh7FFFFFFF, 32'sh80000000,
                                         32'sd100, -32'sd100};

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d reports still due",
               cycles, ledger.pending.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result channel: the block cannot be stalled, every strobe is a report
  always @(posedge clk) begin
    if (!rst && strobe)
      ledger.check_report(status, data, match_index, entries_used, last);
  end

  // mostly pool values, sometimes any 32-bit word
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 60) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Drive one transaction. Entered just after a rising edge; inputs change
  // on falling edges only. Start stays high across back-to-back transactions.
  task automatic issue_command(input logic [2:0] k, input logic [5:0] ix,
                               input logic signed [31:0] v);
    int unsigned gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
    @(negedge clk);
    start = 1'b1;
    kind  = k;
    index = ix;
    value = v;
    // accepted at the first rising edge with busy low
    do @(posedge clk); while (busy);
    ledger.take_command(k, ix, v);
  endtask

  initial begin
    logic signed [31:0] burst_val;
    int unsigned        pick;
    logic [5:0]         ix;
    ledger   = new();
    cycles   = 0;
    idle_pct = 0;
    rst      = 1'b1;
    start    = 1'b0;
    kind     = '0;
    index    = '0;
    value    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // ---- directed: empty table, spare kinds, sign extremes, sort, edges ----
    issue_command(bate_pkg::KIND_READ,   6'd0,  32'sd0);     // read on empty
    issue_command(bate_pkg::KIND_DELETE, 6'd63, 32'sd0);     // delete on empty
    issue_command(bate_pkg::KIND_FIND,   6'd0,  32'sd0);     // no match on empty
    issue_command(bate_pkg::KIND_SORT,   6'd0,  32'sd0);     // sort of nothing
    for (int k = int'(bate_pkg::KIND_SORT) + 1; k < 8; k++)  // spare kinds: no-op
      issue_command(3'(k), 6'd63, -32'sd1);
    issue_command(bate_pkg::KIND_APPEND, 6'd0,  32'sh7FFFFFFF);
    issue_command(bate_pkg::KIND_APPEND, 6'd63, 32'sh80000000);
    issue_command(bate_pkg::KIND_APPEND, 6'd0,  32'sd0);
    issue_command(bate_pkg::KIND_APPEND, 6'd0,  -32'sd1);
    issue_command(bate_pkg::KIND_APPEND, 6'd0,  32'sd5);
    issue_command(bate_pkg::KIND_APPEND, 6'd0,  -32'sd1);
    issue_command(bate_pkg::KIND_READ,   6'd0,  32'sd0);
    issue_command(bate_pkg::KIND_READ,   6'd5,  32'sd0);     // last valid slot
    issue_command(bate_pkg::KIND_READ,   6'd6,  32'sd0);     // one past the end
    issue_command(bate_pkg::KIND_READ,   6'd63, 32'sd0);
    issue_command(bate_pkg::KIND_FIND,   6'd0,  -32'sd1);    // two hits
    issue_command(bate_pkg::KIND_FIND,   6'd0,  32'sd12345); // no hit
    issue_command(bate_pkg::KIND_SORT,   6'd0,  32'sd0);
    issue_command(bate_pkg::KIND_READ,   6'd0,  32'sd0);     // minimum after sort
    issue_command(bate_pkg::KIND_DELETE, 6'd5,  32'sd0);     // delete last
    issue_command(bate_pkg::KIND_DELETE, 6'd0,  32'sd0);     // delete first
    issue_command(bate_pkg::KIND_DELETE, 6'd63, 32'sd0);     // bad index
    issue_command(bate_pkg::KIND_FIND,   6'd0,  32'sh7FFFFFFF);

    // ---- fill to capacity with one word: full-table find, full refusal ----
    idle_pct  = 30;
    burst_val = pick_value();
    while (ledger.fill < Depth)
      issue_command(bate_pkg::KIND_APPEND, 6'($urandom_range(63)), burst_val);
    issue_command(bate_pkg::KIND_FIND,   6'd0,  burst_val);    // the burst's slots match
    issue_command(bate_pkg::KIND_APPEND, 6'd0,  pick_value()); // refused, table full
    issue_command(bate_pkg::KIND_READ,   6'd63, 32'sd0);
    issue_command(bate_pkg::KIND_SORT,   6'd0,  32'sd0);
    issue_command(bate_pkg::KIND_DELETE, 6'd63, 32'sd0);

    // ---- random traffic under four sender idle patterns ----
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      for (int n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        // mostly in-range positions, some anywhere in 0..63
        if (ledger.fill > 0 && $urandom_range(99) < 75)
          ix = 6'($urandom_range(ledger.fill - 1));
        else
          ix = 6'($urandom_range(63));
        if (pick < 30)      issue_command(bate_pkg::KIND_APPEND, ix, pick_value());
        else if (pick < 50) issue_command(bate_pkg::KIND_DELETE, ix, pick_value());
        else if (pick < 70) issue_command(bate_pkg::KIND_READ,   ix, pick_value());
        else if (pick < 88) issue_command(bate_pkg::KIND_FIND,   ix, pick_value());
        else if (pick < 94) issue_command(bate_pkg::KIND_SORT,   ix, pick_value());
        else issue_command(3'($urandom_range(int'(bate_pkg::KIND_SORT) + 1, 7)), ix,
                           $urandom);
      end
    end

    @(negedge clk);
    start = 1'b0;

    // drain: every queued report must arrive, then a quiet tail
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d appends, %0d deletes, %0d reads, %0d finds, %0d sorts, %0d spare-kind ops",
             ledger.kind_seen[bate_pkg::KIND_APPEND], ledger.kind_seen[bate_pkg::KIND_DELETE],
             ledger.kind_seen[bate_pkg::KIND_READ], ledger.kind_seen[bate_pkg::KIND_FIND],
             ledger.kind_seen[bate_pkg::KIND_SORT],
             ledger.kind_seen[5] + ledger.kind_seen[6] + ledger.kind_seen[7]);
    $display("%0d reports checked, longest find %0d hits, %0d full refusals, %0d mismatches",
             ledger.checked, ledger.longest_find, ledger.full_refusals,
             ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/bate_pkg.sv
rtl/bate_ctrl.sv
rtl/bate_dpath.sv
rtl/bounded_array_table_engine_unit.sv
rtl/bate_chk.sv
bench/bounded_array_table_engine_unit_test.sv
